FILE: hw/rtl/tpg_pkg.sv
// tpg_pkg: widths, pipeline depth and register indexes of the trapezoid pulse generator
// no dependencies
`timescale 1ns / 1ps

package tpg_pkg;

  // field widths
  localparam int unsigned LEVEL_WIDTH = 16;
  localparam int unsigned TIME_WIDTH  = 32;

  // derived widths
  localparam int unsigned DUR_W  = TIME_WIDTH - 1;            // timing registers
  localparam int unsigned NUM_W  = TIME_WIDTH + 1;            // |tick - delay|
  localparam int unsigned PROD_W = LEVEL_WIDTH + DUR_W;       // ramp numerator
  localparam int unsigned CFG_W  = (DUR_W > LEVEL_WIDTH) ? DUR_W : LEVEL_WIDTH;
  localparam int unsigned IDX_W  = 3;

  // register stages from the accepting edge to the result
  localparam int unsigned PIPE_DEPTH = NUM_W + LEVEL_WIDTH + 5;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_LEVEL_LOW  = 3'd0,
    CFG_LEVEL_HIGH = 3'd1,
    CFG_DELAY      = 3'd2,
    CFG_RISE       = 3'd3,
    CFG_WIDTH      = 3'd4,
    CFG_FALL       = 3'd5,
    CFG_PERIOD     = 3'd6
  } cfg_idx_e;

endpackage

FILE: hw/rtl/trapezoid_pulse_generator.sv
// trapezoid_pulse_generator: periodic trapezoidal pulse level for a signed tick
// depends on tpg_pkg
`timescale 1ns / 1ps

// A new tick can be started in every clock cycle (busy_o stays low) and its level
// appears on level_o, marked by done_o for one cycle, after it has passed through the
// PIPE_DEPTH register stages; results leave in the order of the ticks and cannot be
// held off. The depth is set by the phase reduction, one remainder bit per stage over
// TIME_WIDTH+1 stages, and the ramp division, one quotient bit per stage over
// LEVEL_WIDTH stages, plus entry, phase, region, multiply and output stages. The user
// must write registers only while no tick is in flight; the block does not enforce this.
module trapezoid_pulse_generator
  import tpg_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [TIME_WIDTH-1:0]  tick_i,
  output logic                          done_o,
  output logic signed [LEVEL_WIDTH-1:0] level_o
);

  localparam int unsigned LW = LEVEL_WIDTH;

  // configuration registers
  logic [LW-1:0]    level_low_q, level_high_q;
  logic [DUR_W-1:0] delay_q, rise_q, width_q, fall_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_low_q  <= '0;
      level_high_q <= '0;
      delay_q      <= '0;
      rise_q       <= '0;
      width_q      <= '0;
      fall_q       <= '0;
      period_q     <= DUR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEVEL_LOW:  level_low_q  <= cfg_data_i[LW-1:0];
        CFG_LEVEL_HIGH: level_high_q <= cfg_data_i[LW-1:0];
        CFG_DELAY:      delay_q      <= cfg_data_i[DUR_W-1:0];
        CFG_RISE:       rise_q       <= cfg_data_i[DUR_W-1:0];
        CFG_WIDTH:      width_q      <= cfg_data_i[DUR_W-1:0];
        CFG_FALL:       fall_q       <= cfg_data_i[DUR_W-1:0];
        CFG_PERIOD:     period_q     <= cfg_data_i[DUR_W-1:0];
        default:        ;
      endcase
    end
  end

  // a zero period acts as one
  logic [DUR_W-1:0] per_eff;
  assign per_eff = (period_q == '0) ? DUR_W'(1) : period_q;

  assign busy_o = 1'b0;

  // entry stage: magnitude and sign of tick - delay
  logic signed [NUM_W-1:0] rel_s;
  logic                    rel_neg;
  logic [NUM_W-1:0]        rel_abs;

  assign rel_s   = $signed({tick_i[TIME_WIDTH-1], tick_i}) - $signed({2'b00, delay_q});
  assign rel_neg = rel_s[NUM_W-1];
  assign rel_abs = rel_neg ? NUM_W'(-rel_s) : NUM_W'(rel_s);

  // phase reduction, one bit of |tick - delay| per stage
  logic             md_v_q   [0:NUM_W];
  logic [DUR_W-1:0] md_r_q   [0:NUM_W];
  logic [NUM_W-1:0] md_n_q   [0:NUM_W];
  logic             md_neg_q [0:NUM_W];
  logic [DUR_W-1:0] md_r_d   [0:NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_mod
    logic [DUR_W:0] sh;
    always_comb begin
      sh = {md_r_q[k], md_n_q[k][NUM_W-1]};
      if (sh >= {1'b0, per_eff}) begin
        sh = sh - {1'b0, per_eff};
      end
      md_r_d[k] = sh[DUR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NUM_W; k++) md_v_q[k] <= 1'b0;
    end else begin
      md_v_q[0] <= start_i;
      for (int k = 0; k < NUM_W; k++) md_v_q[k+1] <= md_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    md_r_q[0]   <= '0;
    md_n_q[0]   <= rel_abs;
    md_neg_q[0] <= rel_neg;
    for (int k = 0; k < NUM_W; k++) begin
      md_r_q[k+1]   <= md_r_d[k];
      md_n_q[k+1]   <= md_n_q[k] << 1;
      md_neg_q[k+1] <= md_neg_q[k];
    end
  end

  // phase stage: fold a negative remainder into 0..period-1
  logic             ph_v_q;
  logic [DUR_W-1:0] ph_q;
  logic [DUR_W-1:0] r_fin;

  assign r_fin = md_r_q[NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_v_q <= 1'b0;
    else         ph_v_q <= md_v_q[NUM_W];
  end

  always_ff @(posedge clk_i) begin
    ph_q <= (md_neg_q[NUM_W] && r_fin != '0) ? per_eff - r_fin : r_fin;
  end

  // region stage: pick ramp operands or a flat level
  logic signed [LW:0] diff;
  logic [LW-1:0]      mag;
  logic [DUR_W:0]     top_end;
  logic [DUR_W+1:0]   fall_end;

  assign diff     = $signed({level_high_q[LW-1], level_high_q})
                  - $signed({level_low_q[LW-1], level_low_q});
  assign mag      = diff[LW] ? LW'(-diff) : LW'(diff);
  assign top_end  = {1'b0, rise_q} + {1'b0, width_q};
  assign fall_end = {1'b0, top_end} + {2'b00, fall_q};

  logic             rg_v_q;
  logic [LW-1:0]    rg_mag_q;
  logic [DUR_W-1:0] rg_el_q, rg_dur_q;
  logic [LW-1:0]    rg_from_q;
  logic             rg_sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rg_v_q <= 1'b0;
    else         rg_v_q <= ph_v_q;
  end

  always_ff @(posedge clk_i) begin
    priority if ({1'b0, ph_q} < {1'b0, rise_q}) begin
      rg_mag_q  <= mag;
      rg_el_q   <= ph_q;
      rg_dur_q  <= rise_q;
      rg_from_q <= level_low_q;
      rg_sub_q  <= diff[LW];
    end else if ({1'b0, ph_q} < top_end) begin
      rg_mag_q  <= '0;
      rg_el_q   <= '0;
      rg_dur_q  <= DUR_W'(1);
      rg_from_q <= level_high_q;
      rg_sub_q  <= 1'b0;
    end else if ({2'b00, ph_q} < fall_end) begin
      rg_mag_q  <= mag;
      rg_el_q   <= ph_q - top_end[DUR_W-1:0];
      rg_dur_q  <= fall_q;
      rg_from_q <= level_high_q;
      rg_sub_q  <= !diff[LW] && (diff != '0);
    end else begin
      rg_mag_q  <= '0;
      rg_el_q   <= '0;
      rg_dur_q  <= DUR_W'(1);
      rg_from_q <= level_low_q;
      rg_sub_q  <= 1'b0;
    end
  end

  // multiply stage feeds the first division stage; quotient stays below 2^LW
  logic             dv_v_q    [0:LW];
  logic [DUR_W-1:0] dv_r_q    [0:LW];
  logic [LW-1:0]    dv_l_q    [0:LW];
  logic [LW-1:0]    dv_qt_q   [0:LW];
  logic [DUR_W-1:0] dv_dur_q  [0:LW];
  logic [LW-1:0]    dv_from_q [0:LW];
  logic             dv_sub_q  [0:LW];
  logic [PROD_W-1:0] prod;
  logic [DUR_W-1:0] dv_r_d    [0:LW-1];
  logic             dv_b_d    [0:LW-1];

  assign prod = PROD_W'(rg_mag_q) * PROD_W'(rg_el_q);

  for (genvar k = 0; k < LW; k++) begin : g_div
    logic [DUR_W:0] sh;
    always_comb begin
      sh        = {dv_r_q[k], dv_l_q[k][LW-1]};
      dv_b_d[k] = (sh >= {1'b0, dv_dur_q[k]});
      if (dv_b_d[k]) begin
        sh = sh - {1'b0, dv_dur_q[k]};
      end
      dv_r_d[k] = sh[DUR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LW; k++) dv_v_q[k] <= 1'b0;
    end else begin
      dv_v_q[0] <= rg_v_q;
      for (int k = 0; k < LW; k++) dv_v_q[k+1] <= dv_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_r_q[0]    <= prod[PROD_W-1:LW];
    dv_l_q[0]    <= prod[LW-1:0];
    dv_qt_q[0]   <= '0;
    dv_dur_q[0]  <= rg_dur_q;
    dv_from_q[0] <= rg_from_q;
    dv_sub_q[0]  <= rg_sub_q;
    for (int k = 0; k < LW; k++) begin
      dv_r_q[k+1]    <= dv_r_d[k];
      dv_l_q[k+1]    <= dv_l_q[k] << 1;
      dv_qt_q[k+1]   <= {dv_qt_q[k][LW-2:0], dv_b_d[k]};
      dv_dur_q[k+1]  <= dv_dur_q[k];
      dv_from_q[k+1] <= dv_from_q[k];
      dv_sub_q[k+1]  <= dv_sub_q[k];
    end
  end

  // output stage: apply the ramp offset
  logic          done_q;
  logic [LW-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_v_q[LW];
  end

  always_ff @(posedge clk_i) begin
    level_q <= dv_sub_q[LW] ? dv_from_q[LW] - dv_qt_q[LW] : dv_from_q[LW] + dv_qt_q[LW];
  end

  assign done_o  = done_q;
  assign level_o = $signed(level_q);

  // assertions
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(PIPE_DEPTH) done_o)
    else $error("result missing after pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_DEPTH))
    else $error("result without a started tick");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_v_q[NUM_W] |-> (md_r_q[NUM_W] < per_eff))
    else $error("phase remainder not below period");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rg_v_q |-> (rg_el_q < rg_dur_q) || (rg_mag_q == '0))
    else $error("ramp offset not below its duration");

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for the trapezoid pulse generator
// depends on tpg_pkg and trapezoid_pulse_generator
`timescale 1ns / 1ps

module testbench;
  import tpg_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 4000;

  // scoreboard: own copy of the registers and the pulse shape
  class pulse_scoreboard;
    logic signed [LEVEL_WIDTH-1:0] lvl_lo, lvl_hi;
    longint dly, rise, wid, fall, per;
    logic signed [LEVEL_WIDTH-1:0] pending_levels[$];
    int unsigned n_errors, n_ticks, n_checked;

    function new();
      lvl_lo = '0; lvl_hi = '0;
      dly = 0; rise = 0; wid = 0; fall = 0; per = 1;
      n_errors = 0; n_ticks = 0; n_checked = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LEVEL_LOW:  lvl_lo = data[LEVEL_WIDTH-1:0];
        CFG_LEVEL_HIGH: lvl_hi = data[LEVEL_WIDTH-1:0];
        CFG_DELAY:      dly  = longint'(data[DUR_W-1:0]);
        CFG_RISE:       rise = longint'(data[DUR_W-1:0]);
        CFG_WIDTH:      wid  = longint'(data[DUR_W-1:0]);
        CFG_FALL:       fall = longint'(data[DUR_W-1:0]);
        CFG_PERIOD:     per  = longint'(data[DUR_W-1:0]);
        default: ;
      endcase
    endfunction

    // linear ramp, offset truncated toward zero
    function longint ramp_level(longint from, longint diff, longint el, longint dur);
      longint mag, q;
      mag = diff < 0 ? -diff : diff;
      q = (mag * el) / dur;
      return diff < 0 ? from - q : from + q;
    endfunction

    function logic signed [LEVEL_WIDTH-1:0] pulse_level(logic signed [TIME_WIDTH-1:0] tk);
      longint lo, hi, diff, p, ph, top_end, fall_end, lv;
      lo = lvl_lo; hi = lvl_hi; diff = hi - lo;
      p = (per == 0) ? 1 : per;
      ph = (longint'(tk) - dly) % p;
      if (ph < 0) ph += p;
      top_end = rise + wid;
      fall_end = top_end + fall;
      if (ph < rise) lv = ramp_level(lo, diff, ph, rise);
      else if (ph < top_end) lv = hi;
      else if (ph < fall_end) lv = ramp_level(hi, -diff, ph - top_end, fall);
      else lv = lo;
      return lv[LEVEL_WIDTH-1:0];
    endfunction

    function void note_tick(logic signed [TIME_WIDTH-1:0] tk);
      pending_levels.push_back(pulse_level(tk));
      n_ticks++;
    endfunction

    function void check_level(logic signed [LEVEL_WIDTH-1:0] got);
      logic signed [LEVEL_WIDTH-1:0] want;
      if (pending_levels.size() == 0) begin
        $error("level %0d arrived with no tick in flight", got);
        n_errors++;
        return;
      end
      want = pending_levels.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("level: expected %0d, got %0d", want, got);
        n_errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [IDX_W-1:0]              cfg_idx_i = '0;
  logic [CFG_W-1:0]              cfg_data_i = '0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic signed [TIME_WIDTH-1:0]  tick_i = '0;
  logic                          done_o;
  logic signed [LEVEL_WIDTH-1:0] level_o;

  pulse_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned n_cfg_sets = 0;

  always #4 clk_i = ~clk_i;

  trapezoid_pulse_generator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_o, .tick_i, .done_o, .level_o
  );

  // monitor: note accepted ticks, check levels, watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_tick(tick_i);
      if (done_o) sb.check_level(level_o);
      if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one register write
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every level is back, then let the pipe settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic set_shape(logic signed [LEVEL_WIDTH-1:0] lo, logic signed [LEVEL_WIDTH-1:0] hi,
                           logic [DUR_W-1:0] d, logic [DUR_W-1:0] r, logic [DUR_W-1:0] w,
                           logic [DUR_W-1:0] f, logic [DUR_W-1:0] p);
    drain();
    write_reg(CFG_LEVEL_LOW,  {15'($urandom), lo});
    write_reg(CFG_LEVEL_HIGH, {15'($urandom), hi});
    write_reg(CFG_DELAY, d);
    write_reg(CFG_RISE, r);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_FALL, f);
    write_reg(CFG_PERIOD, p);
    write_reg(CFG_UNUSED, 31'($urandom));
    n_cfg_sets++;
  endtask

  // one tick transfer, optionally followed by a gap
  task automatic send_tick(logic signed [TIME_WIDTH-1:0] tk, bit allow_gap);
    int unsigned gap;
    start_i <= 1'b1;
    tick_i  <= tk;
    do @(posedge clk_i); while (busy_o);
    gap = 0;
    if (allow_gap) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [DUR_W-1:0] rand_dur();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 31'($urandom);
      2:       return 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 40));
    endcase
  endfunction

  // random ticks, mostly near the delay so every region is hit
  task automatic random_ticks(int n, bit gaps);
    logic signed [TIME_WIDTH-1:0] tk;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) tk = $urandom;
      else tk = 32'(sb.dly) + 32'($urandom_range(0, 300)) - 32'd100;
      send_tick(tk, gaps);
    end
  endtask

  initial begin
    logic signed [TIME_WIDTH-1:0] corner_ticks[6];
    corner_ticks = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh4000_0000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: constant level
    foreach (corner_ticks[i]) send_tick(corner_ticks[i], 1'b0);

    // every region of a full-scale pulse, both directions of the ramp
    set_shape(-16'sd32768, 16'sd32767, 5, 10, 4, 7, 30);
    for (int t = -3; t < 33; t += 2) send_tick(t, 1'b1);
    send_tick(32'sh8000_0000, 1'b0);
    send_tick(32'sh7fff_ffff, 1'b0);
    set_shape(16'sd32767, -16'sd32768, 0, 9, 0, 13, 25);
    for (int t = 0; t < 25; t += 3) send_tick(t, 1'b0);

    // zero rise and fall, zero period, parts longer than the period
    set_shape(-16'sd100, 16'sd200, 3, 0, 5, 0, 12);
    for (int t = 0; t < 14; t++) send_tick(t, 1'b0);
    set_shape(16'sd7, -16'sd9, 31'h7fff_ffff, 4, 2, 3, 0);
    random_ticks(6, 1'b0);
    set_shape(16'sd1000, -16'sd1000, 2, 6, 5, 8, 10);
    for (int t = 0; t < 12; t++) send_tick(t, 1'b0);

    // largest durations
    set_shape(-16'sd32768, 16'sd32767, 31'h7fff_ffff, 31'h7fff_ffff,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    foreach (corner_ticks[i]) send_tick(corner_ticks[i], 1'b0);

    // random shapes, each followed by a batch of ticks
    for (int ph = 0; ph < 10; ph++) begin
      logic [DUR_W-1:0] r, w, f, p;
      r = rand_dur(); w = rand_dur(); f = rand_dur();
      if ($urandom_range(2) == 0) p = rand_dur();
      else p = 31'(r) + 31'(w) + 31'(f) + 31'($urandom_range(0, 20));
      set_shape(16'($urandom), 16'($urandom),
                ($urandom_range(1) != 0) ? 31'($urandom) : rand_dur(),
                r, w, f, p);
      random_ticks(75, ph != 3);
    end

    drain();
    $display("covered %0d ticks over %0d register settings, %0d levels checked",
             sb.n_ticks, n_cfg_sets, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_levels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: trapezoid_pulse_generator.f
hw/rtl/tpg_pkg.sv
hw/rtl/trapezoid_pulse_generator.sv
tb/testbench.sv
